/* rtl/core/aob_pkg.sv */
package aob_pkg;

  localparam int MAX_VOICES      = 128;
  localparam int PHASE_WIDTH     = 32;
  localparam int TABLE_ADDR_BITS = 10;

  localparam int TAB_N    = 1 << TABLE_ADDR_BITS;
  localparam int VIDX_W   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int VCOUNT_W = 8;
  localparam int CNT_W    = ($clog2(MAX_VOICES + 1) > VCOUNT_W) ?
                            $clog2(MAX_VOICES + 1) : VCOUNT_W;

  localparam int FIELD_W   = 32;
  localparam int SAMPLE_W  = 16;
  localparam int SINE_W    = 16;
  localparam int SMAG_W    = 15;
  localparam int TANH_W    = 15;
  localparam int AMP_W     = 23;
  localparam int DRIVE_W   = 16;
  localparam int PROD_W    = DRIVE_W + SMAG_W;
  localparam int TI_SHIFT  = 30 - TABLE_ADDR_BITS;
  localparam int AMP_FRAC  = 23;
  localparam int SAW_P_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [DRIVE_W-1:0] DRIVE_MIN   = 16'd2048;
  localparam logic [AMP_W-1:0]   AMP_RESET   = 23'd8388352;
  localparam logic [TANH_W-1:0]  TANH_SAT    = 15'h7FFF;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [1:0] WAVE_SAW    = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE     = 3'd4;

  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] INV_E_Q30  = 64'd395007542;

  localparam logic [63:0] SINE_DIV [6]  = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
  localparam logic [63:0] EXP_DIV  [12] = '{64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6,
                                            64'd7, 64'd8, 64'd9, 64'd10, 64'd11, 64'd12};

  typedef logic signed [SINE_W-1:0] sine_tab_t [TAB_N];
  typedef logic [TANH_W-1:0]        tanh_tab_t [TAB_N];

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DRAIN,
    SEQ_HOLD
  } seq_state_t;

  typedef struct packed {
    logic valid;
    logic last;
  } voice_tag_t;

  typedef struct packed {
    logic                en;
    logic                last;
    logic [VIDX_W-1:0]   addr;
  } rd_ctl_t;

  typedef struct packed {
    logic [PHASE_WIDTH-1:0] step;
    logic [PHASE_WIDTH-1:0] left;
    logic [PHASE_WIDTH-1:0] right;
  } voice_word_t;

  typedef struct packed {
    logic [1:0]         waveform;
    logic [AMP_W-1:0]   amp;
    logic [DRIVE_W-1:0] drive;
  } osc_cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] saw_mag;
    logic                saw_neg;
    logic                sq_neg;
  } term_pass_t;

  function automatic logic [PHASE_WIDTH-1:0] align_phase(input logic [FIELD_W-1:0] v);
    logic [PHASE_WIDTH+FIELD_W-1:0] w;
    w = {v, PHASE_WIDTH'(0)};
    return w[PHASE_WIDTH+FIELD_W-1 -: PHASE_WIDTH];
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] m);
    logic [63:0] x, x2, pos, neg, t, r, v;
    x   = (m * TWO_PI_Q30) >> TABLE_ADDR_BITS;
    x2  = (x * x) >> 30;
    pos = x;
    neg = 64'd0;
    t   = x;
    for (int i = 1; i <= 6; i++) begin
      t = udiv64((t * x2) >> 30, SINE_DIV[i-1]);
      if ((i & 1) != 0) neg = neg + t;
      else pos = pos + t;
    end
    r = (pos >= neg) ? pos - neg : 64'd0;
    v = (r + 64'd16384) >> 15;
    return (v > 64'd32767) ? 16'd32767 : v[SINE_W-1:0];
  endfunction

  function automatic logic [63:0] exp_neg(input logic [63:0] z);
    logic [63:0] n, f, pos, neg, t, e;
    n   = z >> 30;
    f   = z & (ONE_Q30 - 64'd1);
    pos = ONE_Q30;
    neg = 64'd0;
    t   = ONE_Q30;
    for (int i = 1; i <= 12; i++) begin
      t = udiv64((t * f) >> 30, EXP_DIV[i-1]);
      if ((i & 1) != 0) neg = neg + t;
      else pos = pos + t;
    end
    e = (pos > neg) ? pos - neg : 64'd0;
    for (int j = 0; j < 16; j++) begin
      if (64'(j) < n) e = (e * INV_E_Q30) >> 30;
    end
    return e;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    int          h, m;
    logic [SINE_W-1:0] s;
    for (int k = 0; k < TAB_N; k++) begin
      h = k & (TAB_N / 2 - 1);
      m = (h <= TAB_N / 4) ? h : TAB_N / 2 - h;
      s = quarter_sine(64'(m));
      tab[k] = (k >= TAB_N / 2) ? $signed(-s) : $signed(s);
    end
    return tab;
  endfunction

  function automatic tanh_tab_t build_tanh();
    tanh_tab_t   tab;
    logic [63:0] e, v;
    for (int k = 0; k < TAB_N; k++) begin
      e = exp_neg(64'(k) << (34 - TABLE_ADDR_BITS));
      v = udiv64((ONE_Q30 - e) * 64'd32768 + ((ONE_Q30 + e) >> 1), ONE_Q30 + e);
      tab[k] = (v > 64'd32767) ? TANH_SAT : v[TANH_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

/* rtl/core/aob_voice_mem.sv */
module aob_voice_mem (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [aob_pkg::VIDX_W-1:0] wr_addr,
  input  aob_pkg::voice_word_t     wr_data,
  input  logic                     rd_en,
  input  logic [aob_pkg::VIDX_W-1:0] rd_addr,
  output aob_pkg::voice_word_t     rd_data
);
  import aob_pkg::*;

  voice_word_t mem [MAX_VOICES];
  voice_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/aob_term.sv */
module aob_term (
  input  logic                           clk,
  input  logic                           rst_n,
  input  aob_pkg::osc_cfg_t              cfg,
  input  logic [aob_pkg::PHASE_WIDTH-1:0] phase,
  input  aob_pkg::voice_tag_t            tag_in,
  output logic [aob_pkg::SAMPLE_W-1:0]   term,
  output aob_pkg::voice_tag_t            tag_out
);
  import aob_pkg::*;

  logic [SAW_P_W-1:0]          saw_p;
  logic [SAMPLE_W-1:0]         saw_abs;
  logic [AMP_W+SAMPLE_W-1:0]   saw_prod;
  term_pass_t                  pass0;
  logic [DRIVE_W-1:0]          drive_eff;
  logic                        sneg1;
  logic [SINE_W-1:0]           sine_abs_full;
  logic [SMAG_W-1:0]           sine_abs;
  logic [TANH_W-1:0]           tval;
  logic [SAMPLE_W-1:0]         mag;
  logic                        neg;

  voice_tag_t                  tag1_r, tag2_r, tag3_r, tag4_r, tag5_r;
  term_pass_t                  pass1_r, pass2_r, pass3_r, pass4_r;
  logic signed [SINE_W-1:0]    sine_q1_r;
  logic [PROD_W-1:0]           prod2_r;
  logic                        sneg2_r, sneg3_r, sneg4_r;
  logic [TANH_W-1:0]           tanh_q3_r;
  logic                        big3_r;
  logic [AMP_W+TANH_W-1:0]     tmul4_r;
  logic [SAMPLE_W-1:0]         term_r;

  always_comb begin
    saw_p = phase[PHASE_WIDTH-1 -: SAW_P_W];
    if (saw_p[SAW_P_W-1]) begin
      saw_abs = {1'b0, saw_p[SAW_P_W-2:0]};
      pass0.saw_neg = 1'b0;
    end else begin
      saw_abs = SAMPLE_W'(17'd32768 - {1'b0, saw_p});
      pass0.saw_neg = 1'b1;
    end
    saw_prod = (AMP_W+SAMPLE_W)'(cfg.amp) * (AMP_W+SAMPLE_W)'(saw_abs);
    pass0.saw_mag = saw_prod[AMP_FRAC +: SAMPLE_W];
    pass0.sq_neg = !(phase[PHASE_WIDTH-1] && (|phase[PHASE_WIDTH-2:0]));
  end

  always_ff @(posedge clk) begin
    sine_q1_r <= SINE_TAB[phase[PHASE_WIDTH-1 -: TABLE_ADDR_BITS]];
    pass1_r   <= pass0;
  end

  always_comb begin
    drive_eff     = (cfg.drive < DRIVE_MIN) ? DRIVE_MIN : cfg.drive;
    sneg1         = sine_q1_r[SINE_W-1];
    sine_abs_full = sneg1 ? SINE_W'(-sine_q1_r) : SINE_W'(sine_q1_r);
    sine_abs      = sine_abs_full[SMAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod2_r <= PROD_W'(drive_eff) * PROD_W'(sine_abs);
    sneg2_r <= sneg1;
    pass2_r <= pass1_r;
  end

  always_ff @(posedge clk) begin
    tanh_q3_r <= TANH_TAB[prod2_r[TI_SHIFT +: TABLE_ADDR_BITS]];
    big3_r    <= prod2_r[PROD_W-1];
    sneg3_r   <= sneg2_r;
    pass3_r   <= pass2_r;
  end

  assign tval = big3_r ? TANH_SAT : tanh_q3_r;

  always_ff @(posedge clk) begin
    tmul4_r <= (AMP_W+TANH_W)'(cfg.amp) * (AMP_W+TANH_W)'(tval);
    sneg4_r <= sneg3_r;
    pass4_r <= pass3_r;
  end

  always_comb begin
    case (cfg.waveform)
      WAVE_SAW: begin
        mag = pass4_r.saw_mag;
        neg = pass4_r.saw_neg;
      end
      WAVE_SQUARE: begin
        mag = SAMPLE_W'(cfg.amp[AMP_W-1:8]);
        neg = pass4_r.sq_neg;
      end
      default: begin
        mag = SAMPLE_W'(tmul4_r[AMP_FRAC +: TANH_W]);
        neg = sneg4_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    term_r <= neg ? SAMPLE_W'(-mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
      tag5_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
      tag5_r <= tag4_r;
    end
  end

  assign term    = term_r;
  assign tag_out = tag5_r;

endmodule

/* rtl/core/aob_seq.sv */
module aob_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          tick_go,
  input  logic [aob_pkg::CNT_W-1:0]     voice_total,
  input  logic                          stereo,
  input  aob_pkg::voice_tag_t           term_tag,
  input  logic [aob_pkg::SAMPLE_W-1:0]  term_left,
  input  logic [aob_pkg::SAMPLE_W-1:0]  term_right,
  input  logic                          out_stall,
  output logic                          busy,
  output aob_pkg::rd_ctl_t              rd_ctl,
  output logic                          out_valid,
  output logic signed [aob_pkg::SAMPLE_W-1:0] out_left_sample,
  output logic signed [aob_pkg::SAMPLE_W-1:0] out_right_sample
);
  import aob_pkg::*;

  seq_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] acc_l_r, acc_l_nxt;
  logic [SAMPLE_W-1:0] acc_r_r, acc_r_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_l_r, out_l_nxt;
  logic [SAMPLE_W-1:0] out_r_r, out_r_nxt;
  logic                is_last;
  logic                out_load;

  assign is_last = (cnt_r == voice_total - CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (tick_go) begin
          state_nxt = (voice_total == '0) ? SEQ_HOLD : SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (is_last) state_nxt = SEQ_DRAIN;
      end
      SEQ_DRAIN: begin
        if (term_tag.valid && term_tag.last) state_nxt = SEQ_HOLD;
      end
      SEQ_HOLD: begin
        if (!out_valid_r || !out_stall) state_nxt = SEQ_IDLE;
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    rd_ctl.en   = 1'b0;
    rd_ctl.last = is_last;
    rd_ctl.addr = cnt_r[VIDX_W-1:0];
    out_load    = 1'b0;
    case (state_r)
      SEQ_IDLE:  busy = 1'b0;
      SEQ_RUN:   rd_ctl.en = 1'b1;
      SEQ_DRAIN: rd_ctl.en = 1'b0;
      SEQ_HOLD:  out_load = !out_valid_r || !out_stall;
      default:   busy = 1'b1;
    endcase
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    acc_l_nxt = acc_l_r;
    acc_r_nxt = acc_r_r;
    if (tick_go) begin
      cnt_nxt   = '0;
      acc_l_nxt = '0;
      acc_r_nxt = '0;
    end else begin
      if (rd_ctl.en) cnt_nxt = cnt_r + CNT_W'(1);
      if (term_tag.valid) begin
        acc_l_nxt = acc_l_r + term_left;
        acc_r_nxt = acc_r_r + term_right;
      end
    end
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_l_nxt     = acc_l_r;
      out_r_nxt     = stereo ? acc_r_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_l_r <= acc_l_nxt;
    acc_r_r <= acc_r_nxt;
    out_l_r <= out_l_nxt;
    out_r_r <= out_r_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = $signed(out_l_r);
  assign out_right_sample = $signed(out_r_r);

endmodule

/* rtl/core/additive_oscillator_bank.sv */
// Bank of up to 128 phase-accumulator voices summed into one 16-bit sample
// (stereo pair) per tick word. A load word writes one voice's phase step and
// left/right start phases. A tick word walks voices 0 .. N-1 (N is voice_count
// capped at 128) at one voice per cycle through the single read port of the
// voice memory, then drains a six-stage term pipeline (memory read, sine
// table, drive multiply, tanh table, amplitude multiply, sign); the block is
// busy until the sum is loaded to the output register (no drain when no voice
// is active), also while a finished sample waits on a stalled output. Every
// voice must be loaded before a tick reads it. Configuration must be written
// by the user only while no tick is in flight; the block does not enforce it.
module additive_oscillator_bank (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [6:0]          in_voice_index,
  input  logic [31:0]         in_phase_step,
  input  logic [31:0]         in_start_phase_left,
  input  logic [31:0]         in_start_phase_right,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_left_sample,
  output logic signed [15:0]  out_right_sample,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [22:0]         cfg_wdata
);
  import aob_pkg::*;

  logic [1:0]          waveform_r;
  logic                stereo_r;
  logic [VCOUNT_W-1:0] vcount_r;
  logic [AMP_W-1:0]    amp_r;
  logic [DRIVE_W-1:0]  drive_r;

  logic                in_fire, tick_go, load_go;
  logic [CNT_W-1:0]    load_idx;
  logic                load_ok;
  logic [CNT_W-1:0]    voice_total;
  osc_cfg_t            osc_cfg;
  rd_ctl_t             rd_ctl;
  voice_word_t         rd_word;
  voice_word_t         wr_word;
  logic                wr_en;
  logic [VIDX_W-1:0]   wr_addr;
  voice_tag_t          s1_tag_r;
  logic [VIDX_W-1:0]   s1_addr_r;
  voice_tag_t          tag_l, tag_r;
  logic [SAMPLE_W-1:0] term_l, term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r <= WAVE_SAW;
      stereo_r   <= 1'b0;
      vcount_r   <= VCOUNT_W'(1);
      amp_r      <= AMP_RESET;
      drive_r    <= DRIVE_MIN;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WAVEFORM:  waveform_r <= cfg_wdata[1:0];
        CFG_STEREO:    stereo_r   <= cfg_wdata[0];
        CFG_VCOUNT:    vcount_r   <= cfg_wdata[VCOUNT_W-1:0];
        CFG_AMPLITUDE: amp_r      <= cfg_wdata[AMP_W-1:0];
        CFG_DRIVE:     drive_r    <= cfg_wdata[DRIVE_W-1:0];
        default:       waveform_r <= waveform_r;
      endcase
    end
  end

  assign osc_cfg.waveform = waveform_r;
  assign osc_cfg.amp      = amp_r;
  assign osc_cfg.drive    = drive_r;

  assign voice_total = (CNT_W'(vcount_r) > CNT_W'(MAX_VOICES)) ?
                       CNT_W'(MAX_VOICES) : CNT_W'(vcount_r);

  assign in_fire  = in_valid && !in_stall;
  assign tick_go  = in_fire && (in_operation == OP_TICK);
  assign load_go  = in_fire && (in_operation == OP_LOAD);
  assign load_idx = CNT_W'(in_voice_index);
  assign load_ok  = load_idx < CNT_W'(MAX_VOICES);

  always_comb begin
    if (s1_tag_r.valid) begin
      wr_en         = 1'b1;
      wr_addr       = s1_addr_r;
      wr_word.step  = rd_word.step;
      wr_word.left  = rd_word.left + rd_word.step;
      wr_word.right = stereo_r ? rd_word.right + rd_word.step : rd_word.right;
    end else begin
      wr_en         = load_go && load_ok;
      wr_addr       = load_idx[VIDX_W-1:0];
      wr_word.step  = align_phase(in_phase_step);
      wr_word.left  = align_phase(in_start_phase_left);
      wr_word.right = align_phase(in_start_phase_right);
    end
  end

  aob_voice_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (rd_ctl.en),
    .rd_addr (rd_ctl.addr),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
    end else begin
      s1_tag_r.valid <= rd_ctl.en;
      s1_tag_r.last  <= rd_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= rd_ctl.addr;
  end

  aob_term u_term_l (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (osc_cfg),
    .phase   (rd_word.left),
    .tag_in  (s1_tag_r),
    .term    (term_l),
    .tag_out (tag_l)
  );

  aob_term u_term_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (osc_cfg),
    .phase   (rd_word.right),
    .tag_in  (s1_tag_r),
    .term    (term_r),
    .tag_out (tag_r)
  );

  aob_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .tick_go          (tick_go),
    .voice_total      (voice_total),
    .stereo           (stereo_r),
    .term_tag         (tag_l),
    .term_left        (term_l),
    .term_right       (tag_r.valid ? term_r : '0),
    .out_stall        (out_stall),
    .busy             (in_stall),
    .rd_ctl           (rd_ctl),
    .out_valid        (out_valid),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample)
  );

endmodule

/* verif/additive_oscillator_bank_tb.sv */
`timescale 1ns / 100ps

module additive_oscillator_bank_tb;
  import aob_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 1500;

  localparam logic [1:0] WAVE_TANH     = 2'd2;
  localparam logic [1:0] WAVE_TANH_ALT = 2'd3;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic        op;
    logic [6:0]  voice;
    logic [31:0] step;
    logic [31:0] left;
    logic [31:0] right;
  } osc_word_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } sample_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_operation = OP_TICK;
  logic [6:0]        in_voice_index = '0;
  logic [31:0]       in_phase_step = '0;
  logic [31:0]       in_start_phase_left = '0;
  logic [31:0]       in_start_phase_right = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [15:0] out_left_sample;
  logic signed [15:0] out_right_sample;
  logic              cfg_wr_en = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [22:0]       cfg_wdata = '0;

  logic [1:0]  cfg_wave   = WAVE_SAW;
  logic        cfg_stereo = 1'b0;
  logic [7:0]  cfg_count  = 8'd1;
  logic [22:0] cfg_amp    = AMP_RESET;
  logic [15:0] cfg_drive  = DRIVE_MIN;

  int          sine_lut [TAB_N];
  int unsigned tanh_lut [TAB_N];

  logic [31:0] left_ph  [MAX_VOICES];
  logic [31:0] right_ph [MAX_VOICES];
  logic [31:0] step_ph  [MAX_VOICES];
  bit          voice_loaded [MAX_VOICES];

  logic [31:0] phase_corners [5] = '{32'h0000_0000, 32'h8000_0000, 32'h8000_0001,
                                     32'h7FFF_FFFF, 32'hFFFF_FFFF};

  osc_word_t    pending_words [$];
  osc_word_t    in_flight;
  sample_pair_t expected_samples [$];

  idle_mode_t idle_mode = IDLE_NONE;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  int words_pushed = 0;
  int words_taken = 0;
  int loads_taken = 0;
  int ticks_taken = 0;
  int samples_checked = 0;
  int errors = 0;
  int setups = 0;
  int cycle_count = 0;

  always #6 clk = ~clk;

  additive_oscillator_bank i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_voice_index       (in_voice_index),
    .in_phase_step        (in_phase_step),
    .in_start_phase_left  (in_start_phase_left),
    .in_start_phase_right (in_start_phase_right),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_left_sample      (out_left_sample),
    .out_right_sample     (out_right_sample),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  function automatic int unsigned sine_quarter_q15(int unsigned m);
    bit [63:0] x, x2, up, dn, t, v;
    x  = (64'(m) * TWO_PI_Q30) >> TABLE_ADDR_BITS;
    x2 = (x * x) >> 30;
    up = x;
    dn = 64'd0;
    t  = x;
    for (int i = 1; i <= 6; i++) begin
      t = ((t * x2) >> 30) / (64'(2 * i) * 64'(2 * i + 1));
      if (i % 2 == 1) dn += t;
      else up += t;
    end
    v = (up >= dn) ? up - dn : 64'd0;
    v = (v + 64'd16384) >> 15;
    return (v > 64'd32767) ? 32767 : int'(v);
  endfunction

  function automatic bit [63:0] exp_minus_q30(bit [63:0] z);
    bit [63:0] n, f, up, dn, t, e;
    n  = z >> 30;
    f  = z & (ONE_Q30 - 64'd1);
    up = ONE_Q30;
    dn = 64'd0;
    t  = ONE_Q30;
    for (int i = 1; i <= 12; i++) begin
      t = ((t * f) >> 30) / 64'(i);
      if (i % 2 == 1) dn += t;
      else up += t;
    end
    e = (up > dn) ? up - dn : 64'd0;
    while (n > 0) begin
      e = (e * INV_E_Q30) >> 30;
      n--;
    end
    return e;
  endfunction

  function automatic void build_luts();
    int h, m, s;
    bit [63:0] e, v;
    for (int k = 0; k < TAB_N; k++) begin
      h = k & (TAB_N / 2 - 1);
      m = (h <= TAB_N / 4) ? h : TAB_N / 2 - h;
      s = int'(sine_quarter_q15(m));
      sine_lut[k] = (k >= TAB_N / 2) ? -s : s;
      e = exp_minus_q30(64'(k) << (34 - TABLE_ADDR_BITS));
      v = ((ONE_Q30 - e) * 64'd32768 + (ONE_Q30 + e) / 2) / (ONE_Q30 + e);
      tanh_lut[k] = (v > 64'd32767) ? 32767 : int'(v);
    end
  endfunction

  function automatic logic [15:0] voice_term(logic [31:0] ph);
    bit [63:0] mag, lvl, addr, p;
    bit neg;
    int s;
    if (cfg_wave == WAVE_SQUARE) begin
      mag = 64'(cfg_amp) >> 8;
      neg = (ph <= 32'h8000_0000);
    end else if (cfg_wave == WAVE_SAW) begin
      p   = 64'(ph[31:16]);
      neg = (p < 64'd32768);
      mag = (64'(cfg_amp) * (neg ? 64'd32768 - p : p - 64'd32768)) >> 23;
    end else begin
      s    = sine_lut[ph[31 -: TABLE_ADDR_BITS]];
      neg  = (s < 0);
      addr = (64'((cfg_drive < DRIVE_MIN) ? DRIVE_MIN : cfg_drive) * 64'(neg ? -s : s))
             >> (30 - TABLE_ADDR_BITS);
      lvl  = (addr >= TAB_N) ? 64'd32767 : 64'(tanh_lut[addr[TABLE_ADDR_BITS-1:0]]);
      mag  = (64'(cfg_amp) * lvl) >> 23;
    end
    return neg ? 16'(-mag) : mag[15:0];
  endfunction

  task automatic apply_word(osc_word_t w);
    logic [15:0] sum_l, sum_r;
    int n;
    sample_pair_t r;
    if (w.op == OP_LOAD) begin
      step_ph[w.voice]  = w.step;
      left_ph[w.voice]  = w.left;
      right_ph[w.voice] = w.right;
      loads_taken++;
    end else begin
      sum_l = '0;
      sum_r = '0;
      n = (cfg_count > MAX_VOICES) ? MAX_VOICES : cfg_count;
      for (int v = 0; v < n; v++) begin
        sum_l += voice_term(left_ph[v]);
        left_ph[v] = left_ph[v] + step_ph[v];
        if (cfg_stereo) begin
          sum_r += voice_term(right_ph[v]);
          right_ph[v] = right_ph[v] + step_ph[v];
        end
      end
      r.left  = sum_l;
      r.right = cfg_stereo ? sum_r : 16'sd0;
      expected_samples.push_back(r);
      ticks_taken++;
    end
  endtask

  always @(posedge clk) begin : drive_words
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 61 : (idle_mode == IDLE_BOTH) ? 24 : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_word(in_flight);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_flight = pending_words.pop_front();
          in_valid             <= 1'b1;
          in_operation         <= in_flight.op;
          in_voice_index       <= in_flight.voice;
          in_phase_step        <= in_flight.step;
          in_start_phase_left  <= in_flight.left;
          in_start_phase_right <= in_flight.right;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_samples
    sample_pair_t want;
    int unsigned stall_pct;
    stall_pct = (idle_mode == IDLE_RECV) ? 61 : (idle_mode == IDLE_BOTH) ? 24 : 0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample word: left %0d right %0d",
                 out_left_sample, out_right_sample);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_left_sample !== want.left) begin
            $error("left_sample: expected %0d, got %0d", want.left, out_left_sample);
            errors++;
          end
          if (out_right_sample !== want.right) begin
            $error("right_sample: expected %0d, got %0d", want.right, out_right_sample);
            errors++;
          end
          samples_checked++;
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
        out_stall    <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        holds_served <= holds_served + 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding",
               cycle_count, expected_samples.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] pick_phase();
    return ($urandom_range(4) == 0) ? phase_corners[$urandom_range(4)] : $urandom();
  endfunction

  task automatic push_load(int v, logic [31:0] step, logic [31:0] left, logic [31:0] right);
    osc_word_t w;
    w.op    = OP_LOAD;
    w.voice = 7'(v);
    w.step  = step;
    w.left  = left;
    w.right = right;
    pending_words.push_back(w);
    voice_loaded[v] = 1'b1;
    words_pushed++;
  endtask

  task automatic push_tick();
    osc_word_t w;
    int n;
    n = (cfg_count > MAX_VOICES) ? MAX_VOICES : cfg_count;
    for (int v = 0; v < n; v++) begin
      if (!voice_loaded[v]) push_load(v, pick_phase(), pick_phase(), pick_phase());
    end
    w.op    = OP_TICK;
    w.voice = 7'($urandom_range(127));
    w.step  = $urandom();
    w.left  = $urandom();
    w.right = $urandom();
    pending_words.push_back(w);
    words_pushed++;
  endtask

  task automatic push_random(int n);
    repeat (n) begin
      if ($urandom_range(9) < 3)
        push_load($urandom_range(127), pick_phase(), pick_phase(), pick_phase());
      else
        push_tick();
    end
  endtask

  task automatic wait_idle();
    while (words_taken != words_pushed || expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [22:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_WAVEFORM:  cfg_wave   = data[1:0];
      CFG_STEREO:    cfg_stereo = data[0];
      CFG_VCOUNT:    cfg_count  = data[7:0];
      CFG_AMPLITUDE: cfg_amp    = data;
      CFG_DRIVE:     cfg_drive  = data[15:0];
      default: ;
    endcase
  endtask

  task automatic reconfigure(idle_mode_t mode, logic [1:0] wave, logic stereo,
                             int count, int unsigned amp, int unsigned drive);
    wait_idle();
    cfg_write(CFG_WAVEFORM, 23'(wave));
    cfg_write(CFG_STEREO, 23'(stereo));
    cfg_write(CFG_VCOUNT, 23'(count));
    cfg_write(CFG_AMPLITUDE, 23'(amp));
    cfg_write(CFG_DRIVE, 23'(drive));
    idle_mode = mode;
    setups++;
  endtask

  initial begin
    build_luts();
    for (int v = 0; v < MAX_VOICES; v++) begin
      left_ph[v]  = '0;
      right_ph[v] = '0;
      step_ph[v]  = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    reconfigure(IDLE_NONE, WAVE_SAW, 1'b1, 2, AMP_RESET, DRIVE_MIN);
    push_load(0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    push_load(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_load(127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    repeat (3) push_tick();
    push_load(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
    repeat (2) push_tick();

    reconfigure(IDLE_NONE, WAVE_SQUARE, 1'b1, 2, 23'h7FFFFF, DRIVE_MIN);
    push_load(0, 32'h0000_0001, 32'h8000_0000, 32'h8000_0001);
    push_load(1, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    repeat (2) push_tick();

    reconfigure(IDLE_NONE, WAVE_TANH_ALT, 1'b1, 2, AMP_RESET, 0);
    push_load(0, 32'h0400_0000, 32'h4000_0000, 32'hC000_0000);
    repeat (2) push_tick();

    reconfigure(IDLE_NONE, WAVE_TANH, 1'b0, 2, 23'h7FFFFF, 16'hFFFF);
    repeat (2) push_tick();

    reconfigure(IDLE_NONE, WAVE_SAW, 1'b1, 0, AMP_RESET, DRIVE_MIN);
    repeat (2) push_tick();

    reconfigure(IDLE_NONE, WAVE_SAW, 1'b1, 4, AMP_RESET, DRIVE_MIN);
    push_random(100);
    reconfigure(IDLE_SEND, WAVE_SQUARE, 1'b0, 1, 23'h7FFFFF, DRIVE_MIN);
    push_random(100);
    reconfigure(IDLE_RECV, WAVE_TANH, 1'b1, 8, 1048544, 30000);
    push_random(100);
    reconfigure(IDLE_BOTH, WAVE_TANH_ALT, 1'b0, 3, 0, 0);
    push_random(60);
    reconfigure(IDLE_NONE, WAVE_SAW, 1'b0, 0, AMP_RESET, DRIVE_MIN);
    push_random(30);
    reconfigure(IDLE_SEND, WAVE_SQUARE, 1'b1, 128, $urandom_range(23'h7FFFFF), 65535);
    push_random(20);
    reconfigure(IDLE_RECV, WAVE_TANH, 1'b1, 255, $urandom_range(23'h7FFFFF), 65535);
    push_random(15);
    reconfigure(IDLE_BOTH, WAVE_SAW, 1'b1, 16, 2047 * 256, $urandom_range(65535));
    push_random(100);

    reconfigure(IDLE_NONE, WAVE_TANH, 1'b1, 2, AMP_RESET, 8192);
    hold_requests++;
    push_random(100);

    reconfigure(IDLE_SEND, WAVE_TANH_ALT, 1'b1, 6, $urandom_range(23'h7FFFFF), 2047);
    push_random(100);
    reconfigure(IDLE_RECV, WAVE_SQUARE, 1'b0, 12, $urandom_range(23'h7FFFFF),
                $urandom_range(65535));
    push_random(100);
    reconfigure(IDLE_BOTH, WAVE_SAW, 1'b1, 129, $urandom_range(23'h7FFFFF),
                $urandom_range(65535));
    push_random(15);
    reconfigure(IDLE_NONE, WAVE_TANH, 1'b0, 5, 1, 65535);
    push_random(100);
    reconfigure(IDLE_SEND, WAVE_TANH, 1'b1, 10, $urandom_range(23'h7FFFFF),
                $urandom_range(65535));
    push_random(100);

    wait_idle();
    $display("%0d words taken (%0d loads, %0d ticks), %0d samples checked, %0d errors",
             words_taken, loads_taken, ticks_taken, samples_checked, errors);
    $display("%0d register setups: saw, square, tanh sine, mono/stereo, 0..255 voices",
             setups);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
